### hw/rtl/alsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alsf_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int IN_W   = 24;
  localparam int PROD_W = 2 * IN_W;
  localparam int OUT_W  = 32;
  localparam int WIDE_W = 320;
  localparam int RF_AW  = 6;
  localparam int RF_DEPTH = 1 << RF_AW;
  localparam int PC_W   = 7;
  localparam int MOM_N  = 15;
  localparam int LD_W   = 5;
  localparam int LD_N   = 23;
  localparam int ROWS   = 3;

  localparam logic [WIDE_W-1:0] FRAC_ONE = WIDE_W'(17'h10000);

  typedef struct packed {
    logic signed [IN_W-1:0] cam_x;
    logic signed [IN_W-1:0] cam_y;
    logic signed [IN_W-1:0] cam_z;
    logic signed [IN_W-1:0] world_x;
    logic signed [IN_W-1:0] world_y;
    logic signed [IN_W-1:0] world_z;
    logic                   last_point;
  } in_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic signed [OUT_W-1:0] coef_x;
    logic signed [OUT_W-1:0] coef_y;
    logic signed [OUT_W-1:0] coef_z;
    logic signed [OUT_W-1:0] offset;
    logic                    singular;
    logic                    last_row;
  } out_t;

  typedef enum logic [2:0] {OP_END, OP_MUL, OP_ADD, OP_SUB, OP_DIV} op_t;
  typedef enum logic [1:0] {F_CX, F_CY, F_CZ, F_OFS} fld_t;
  typedef enum logic [2:0] {SEL_CX, SEL_CY, SEL_CZ, SEL_WX, SEL_WY, SEL_WZ} sel_t;
  typedef enum logic [2:0] {LD_CNT, LD_CSUM, LD_WSUM, LD_MOM, LD_K} ld_kind_t;

  typedef struct packed {
    op_t              op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] a;
    logic [RF_AW-1:0] b;
  } inst_t;

  typedef struct packed {
    ld_kind_t         kind;
    logic [3:0]       idx;
    logic [RF_AW-1:0] addr;
  } ld_t;

  // register file slots; slots from R_ST up are per row, stride ROW_STRIDE
  localparam logic [RF_AW-1:0] R_N    = 6'd0;
  localparam logic [RF_AW-1:0] R_SC0  = 6'd1;
  localparam logic [RF_AW-1:0] R_SC1  = 6'd2;
  localparam logic [RF_AW-1:0] R_SC2  = 6'd3;
  localparam logic [RF_AW-1:0] R_A00  = 6'd4;
  localparam logic [RF_AW-1:0] R_A11  = 6'd5;
  localparam logic [RF_AW-1:0] R_A22  = 6'd6;
  localparam logic [RF_AW-1:0] R_A01  = 6'd7;
  localparam logic [RF_AW-1:0] R_A02  = 6'd8;
  localparam logic [RF_AW-1:0] R_A12  = 6'd9;
  localparam logic [RF_AW-1:0] R_C00  = 6'd10;
  localparam logic [RF_AW-1:0] R_C11  = 6'd11;
  localparam logic [RF_AW-1:0] R_C22  = 6'd12;
  localparam logic [RF_AW-1:0] R_C01  = 6'd13;
  localparam logic [RF_AW-1:0] R_C02  = 6'd14;
  localparam logic [RF_AW-1:0] R_C12  = 6'd15;
  localparam logic [RF_AW-1:0] R_DET  = 6'd16;
  localparam logic [RF_AW-1:0] R_ND   = 6'd17;
  localparam logic [RF_AW-1:0] R_K    = 6'd18;
  localparam logic [RF_AW-1:0] R_ONUM = 6'd19;
  localparam logic [RF_AW-1:0] R_NUM  = 6'd20;
  localparam logic [RF_AW-1:0] R_T    = 6'd21;
  localparam logic [RF_AW-1:0] R_T2   = 6'd22;
  localparam logic [RF_AW-1:0] R_ST   = 6'd24;
  localparam logic [RF_AW-1:0] R_B0   = 6'd25;
  localparam logic [RF_AW-1:0] R_B1   = 6'd26;
  localparam logic [RF_AW-1:0] R_B2   = 6'd27;
  localparam logic [RF_AW-1:0] ROW_STRIDE = 6'd4;

  localparam logic [PC_W-1:0] P_SETUP = 7'd0;
  localparam logic [PC_W-1:0] P_ROW   = 7'd43;
  localparam logic [PC_W-1:0] P_SING  = 7'd82;

  function automatic inst_t ins(input op_t op, input logic [RF_AW-1:0] d,
                                input logic [RF_AW-1:0] a, input logic [RF_AW-1:0] b);
    inst_t r;
    r.op = op;
    r.dst = d;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  function automatic logic [RF_AW-1:0] eff(input logic [RF_AW-1:0] a, input logic [1:0] row);
    return (a >= R_ST) ? a + {2'b00, row, 2'b00} : a;
  endfunction

  function automatic inst_t prog(input logic [PC_W-1:0] pc);
    inst_t r;
    unique case (pc)
      // centered covariances
      7'd0:  r = ins(OP_MUL, R_T,   R_N,   R_A00);
      7'd1:  r = ins(OP_MUL, R_T2,  R_SC0, R_SC0);
      7'd2:  r = ins(OP_SUB, R_A00, R_T,   R_T2);
      7'd3:  r = ins(OP_MUL, R_T,   R_N,   R_A11);
      7'd4:  r = ins(OP_MUL, R_T2,  R_SC1, R_SC1);
      7'd5:  r = ins(OP_SUB, R_A11, R_T,   R_T2);
      7'd6:  r = ins(OP_MUL, R_T,   R_N,   R_A22);
      7'd7:  r = ins(OP_MUL, R_T2,  R_SC2, R_SC2);
      7'd8:  r = ins(OP_SUB, R_A22, R_T,   R_T2);
      7'd9:  r = ins(OP_MUL, R_T,   R_N,   R_A01);
      7'd10: r = ins(OP_MUL, R_T2,  R_SC0, R_SC1);
      7'd11: r = ins(OP_SUB, R_A01, R_T,   R_T2);
      7'd12: r = ins(OP_MUL, R_T,   R_N,   R_A02);
      7'd13: r = ins(OP_MUL, R_T2,  R_SC0, R_SC2);
      7'd14: r = ins(OP_SUB, R_A02, R_T,   R_T2);
      7'd15: r = ins(OP_MUL, R_T,   R_N,   R_A12);
      7'd16: r = ins(OP_MUL, R_T2,  R_SC1, R_SC2);
      7'd17: r = ins(OP_SUB, R_A12, R_T,   R_T2);
      // cofactors, symmetric
      7'd18: r = ins(OP_MUL, R_T,   R_A11, R_A22);
      7'd19: r = ins(OP_MUL, R_T2,  R_A12, R_A12);
      7'd20: r = ins(OP_SUB, R_C00, R_T,   R_T2);
      7'd21: r = ins(OP_MUL, R_T,   R_A22, R_A00);
      7'd22: r = ins(OP_MUL, R_T2,  R_A02, R_A02);
      7'd23: r = ins(OP_SUB, R_C11, R_T,   R_T2);
      7'd24: r = ins(OP_MUL, R_T,   R_A00, R_A11);
      7'd25: r = ins(OP_MUL, R_T2,  R_A01, R_A01);
      7'd26: r = ins(OP_SUB, R_C22, R_T,   R_T2);
      7'd27: r = ins(OP_MUL, R_T,   R_A12, R_A02);
      7'd28: r = ins(OP_MUL, R_T2,  R_A01, R_A22);
      7'd29: r = ins(OP_SUB, R_C01, R_T,   R_T2);
      7'd30: r = ins(OP_MUL, R_T,   R_A01, R_A12);
      7'd31: r = ins(OP_MUL, R_T2,  R_A11, R_A02);
      7'd32: r = ins(OP_SUB, R_C02, R_T,   R_T2);
      7'd33: r = ins(OP_MUL, R_T,   R_A02, R_A01);
      7'd34: r = ins(OP_MUL, R_T2,  R_A12, R_A00);
      7'd35: r = ins(OP_SUB, R_C12, R_T,   R_T2);
      // determinant
      7'd36: r = ins(OP_MUL, R_T,   R_A00, R_C00);
      7'd37: r = ins(OP_MUL, R_T2,  R_A01, R_C01);
      7'd38: r = ins(OP_ADD, R_T,   R_T,   R_T2);
      7'd39: r = ins(OP_MUL, R_T2,  R_A02, R_C02);
      7'd40: r = ins(OP_ADD, R_DET, R_T,   R_T2);
      7'd41: r = ins(OP_MUL, R_ND,  R_N,   R_DET);
      7'd42: r = ins(OP_END, R_N,   R_N,   R_N);
      // one world row
      7'd43: r = ins(OP_MUL, R_T,   R_N,   R_B0);
      7'd44: r = ins(OP_MUL, R_T2,  R_ST,  R_SC0);
      7'd45: r = ins(OP_SUB, R_B0,  R_T,   R_T2);
      7'd46: r = ins(OP_MUL, R_T,   R_N,   R_B1);
      7'd47: r = ins(OP_MUL, R_T2,  R_ST,  R_SC1);
      7'd48: r = ins(OP_SUB, R_B1,  R_T,   R_T2);
      7'd49: r = ins(OP_MUL, R_T,   R_N,   R_B2);
      7'd50: r = ins(OP_MUL, R_T2,  R_ST,  R_SC2);
      7'd51: r = ins(OP_SUB, R_B2,  R_T,   R_T2);
      7'd52: r = ins(OP_MUL, R_ONUM, R_ST, R_DET);
      7'd53: r = ins(OP_MUL, R_T,   R_C00, R_B0);
      7'd54: r = ins(OP_MUL, R_T2,  R_C01, R_B1);
      7'd55: r = ins(OP_ADD, R_T,   R_T,   R_T2);
      7'd56: r = ins(OP_MUL, R_T2,  R_C02, R_B2);
      7'd57: r = ins(OP_ADD, R_NUM, R_T,   R_T2);
      7'd58: r = ins(OP_MUL, R_T,   R_NUM, R_SC0);
      7'd59: r = ins(OP_SUB, R_ONUM, R_ONUM, R_T);
      7'd60: r = ins(OP_MUL, R_T,   R_NUM, R_K);
      7'd61: r = ins(OP_DIV, RF_AW'(F_CX), R_T, R_DET);
      7'd62: r = ins(OP_MUL, R_T,   R_C01, R_B0);
      7'd63: r = ins(OP_MUL, R_T2,  R_C11, R_B1);
      7'd64: r = ins(OP_ADD, R_T,   R_T,   R_T2);
      7'd65: r = ins(OP_MUL, R_T2,  R_C12, R_B2);
      7'd66: r = ins(OP_ADD, R_NUM, R_T,   R_T2);
      7'd67: r = ins(OP_MUL, R_T,   R_NUM, R_SC1);
      7'd68: r = ins(OP_SUB, R_ONUM, R_ONUM, R_T);
      7'd69: r = ins(OP_MUL, R_T,   R_NUM, R_K);
      7'd70: r = ins(OP_DIV, RF_AW'(F_CY), R_T, R_DET);
      7'd71: r = ins(OP_MUL, R_T,   R_C02, R_B0);
      7'd72: r = ins(OP_MUL, R_T2,  R_C12, R_B1);
      7'd73: r = ins(OP_ADD, R_T,   R_T,   R_T2);
      7'd74: r = ins(OP_MUL, R_T2,  R_C22, R_B2);
      7'd75: r = ins(OP_ADD, R_NUM, R_T,   R_T2);
      7'd76: r = ins(OP_MUL, R_T,   R_NUM, R_SC2);
      7'd77: r = ins(OP_SUB, R_ONUM, R_ONUM, R_T);
      7'd78: r = ins(OP_MUL, R_T,   R_NUM, R_K);
      7'd79: r = ins(OP_DIV, RF_AW'(F_CZ), R_T, R_DET);
      7'd80: r = ins(OP_DIV, RF_AW'(F_OFS), R_ONUM, R_ND);
      7'd81: r = ins(OP_END, R_N,   R_N,   R_N);
      // singular row: world mean only
      7'd82: r = ins(OP_DIV, RF_AW'(F_OFS), R_ST, R_N);
      default: r = ins(OP_END, R_N, R_N, R_N);
    endcase
    return r;
  endfunction

  function automatic ld_t ld_entry(input logic [LD_W-1:0] s);
    ld_t r;
    unique case (s)
      5'd0:  r = '{LD_CNT,  4'd0,  R_N};
      5'd1:  r = '{LD_CSUM, 4'd0,  R_SC0};
      5'd2:  r = '{LD_CSUM, 4'd1,  R_SC1};
      5'd3:  r = '{LD_CSUM, 4'd2,  R_SC2};
      5'd4:  r = '{LD_MOM,  4'd0,  R_A00};
      5'd5:  r = '{LD_MOM,  4'd1,  R_A11};
      5'd6:  r = '{LD_MOM,  4'd2,  R_A22};
      5'd7:  r = '{LD_MOM,  4'd3,  R_A01};
      5'd8:  r = '{LD_MOM,  4'd4,  R_A02};
      5'd9:  r = '{LD_MOM,  4'd5,  R_A12};
      5'd10: r = '{LD_WSUM, 4'd0,  R_ST};
      5'd11: r = '{LD_WSUM, 4'd1,  R_ST + ROW_STRIDE};
      5'd12: r = '{LD_WSUM, 4'd2,  R_ST + (ROW_STRIDE << 1)};
      5'd13: r = '{LD_MOM,  4'd6,  R_B0};
      5'd14: r = '{LD_MOM,  4'd7,  R_B1};
      5'd15: r = '{LD_MOM,  4'd8,  R_B2};
      5'd16: r = '{LD_MOM,  4'd9,  R_B0 + ROW_STRIDE};
      5'd17: r = '{LD_MOM,  4'd10, R_B1 + ROW_STRIDE};
      5'd18: r = '{LD_MOM,  4'd11, R_B2 + ROW_STRIDE};
      5'd19: r = '{LD_MOM,  4'd12, R_B0 + (ROW_STRIDE << 1)};
      5'd20: r = '{LD_MOM,  4'd13, R_B1 + (ROW_STRIDE << 1)};
      5'd21: r = '{LD_MOM,  4'd14, R_B2 + (ROW_STRIDE << 1)};
      default: r = '{LD_K,  4'd0,  R_K};
    endcase
    return r;
  endfunction

  // moment order: xx yy zz xy xz yz, then world*3 + camera
  function automatic sel_t mom_l(input logic [3:0] k);
    sel_t r;
    unique case (k)
      4'd0, 4'd3, 4'd4: r = SEL_CX;
      4'd1, 4'd5:       r = SEL_CY;
      4'd2:             r = SEL_CZ;
      4'd6, 4'd7, 4'd8: r = SEL_WX;
      4'd9, 4'd10, 4'd11: r = SEL_WY;
      default:          r = SEL_WZ;
    endcase
    return r;
  endfunction

  function automatic sel_t mom_r(input logic [3:0] k);
    sel_t r;
    unique case (k)
      4'd0, 4'd6, 4'd9, 4'd12:        r = SEL_CX;
      4'd1, 4'd3, 4'd7, 4'd10, 4'd13: r = SEL_CY;
      default:                        r = SEL_CZ;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/affine_least_squares_fit_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Least-squares affine fit, camera to world. Each pair is taken in one
// transfer, then its fifteen moment products go through one shared 24x24
// multiplier; the block stalls its input meanwhile. The pair with last_point
// starts the solve: a copy of the sums into a 64-entry 320-bit register file,
// then a small microprogram on one shift-add multiplier, one adder and one
// restoring divider. A full solve ends with three row transfers, x then y then
// z. Pairs beyond MAX_POINTS are dropped from the sums. Accumulators clear
// after the third row.
module affine_least_squares_fit_unit #(
  parameter int MAX_POINTS = alsf_pkg::DEF_MAX_POINTS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire alsf_pkg::in_t  item,
  output logic                result_valid,
  input  wire logic           result_stall,
  output alsf_pkg::out_t      result
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = alsf_pkg::IN_W + $clog2(MAX_POINTS);
  localparam int MOM_W = alsf_pkg::PROD_W + $clog2(MAX_POINTS);
  localparam int W     = alsf_pkg::WIDE_W;
  localparam int DC_W  = $clog2(W);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_LOAD, S_FETCH, S_EXEC, S_MUL, S_DIV, S_DIVF, S_OUT
  } state_t;

  state_t state;
  alsf_pkg::in_t pt;
  logic [CNT_W-1:0] count;
  logic signed [SUM_W-1:0] csum [3];
  logic signed [SUM_W-1:0] wsum [3];
  logic signed [MOM_W-1:0] mom [alsf_pkg::MOM_N];
  logic [3:0] kstep;
  logic [alsf_pkg::LD_W-1:0] ls;
  logic [alsf_pkg::PC_W-1:0] pc;
  logic [1:0] k;
  logic in_row;
  logic detz;
  logic signed [alsf_pkg::OUT_W-1:0] fld [4];

  logic [W-1:0] mem [alsf_pkg::RF_DEPTH];
  logic [W-1:0] rd_a, rd_b;
  logic [W-1:0] mx, my, acc;
  logic [W-1:0] dn, dv, rem;
  logic [alsf_pkg::OUT_W-1:0] q;
  logic qov, neg;
  logic [DC_W-1:0] dcnt;

  alsf_pkg::inst_t ins;
  alsf_pkg::ld_t ld;
  logic [alsf_pkg::RF_AW-1:0] ra, rb, wa_ins;
  logic [W-1:0] alu, ld_val;
  logic mem_we;
  logic [alsf_pkg::RF_AW-1:0] mem_wa;
  logic [W-1:0] mem_wd;
  logic [W-1:0] rsh, rsub;
  logic ge;
  logic signed [alsf_pkg::OUT_W-1:0] sat;
  logic signed [alsf_pkg::IN_W-1:0] opl, opr;
  logic signed [alsf_pkg::PROD_W-1:0] prod;

  function automatic logic signed [alsf_pkg::IN_W-1:0] pick(input alsf_pkg::sel_t s,
                                                            input alsf_pkg::in_t p);
    logic signed [alsf_pkg::IN_W-1:0] r;
    unique case (s)
      alsf_pkg::SEL_CX: r = p.cam_x;
      alsf_pkg::SEL_CY: r = p.cam_y;
      alsf_pkg::SEL_CZ: r = p.cam_z;
      alsf_pkg::SEL_WX: r = p.world_x;
      alsf_pkg::SEL_WY: r = p.world_y;
      default:          r = p.world_z;
    endcase
    return r;
  endfunction

  assign item_stall = (state != S_IDLE);

  assign opl  = pick(alsf_pkg::mom_l(kstep), pt);
  assign opr  = pick(alsf_pkg::mom_r(kstep), pt);
  assign prod = opl * opr;

  assign ins    = alsf_pkg::prog(pc);
  assign ra     = alsf_pkg::eff(ins.a, k);
  assign rb     = alsf_pkg::eff(ins.b, k);
  assign wa_ins = alsf_pkg::eff(ins.dst, k);
  assign alu    = (ins.op == alsf_pkg::OP_SUB) ? rd_a - rd_b : rd_a + rd_b;
  assign ld     = alsf_pkg::ld_entry(ls);

  always_comb begin
    unique case (ld.kind)
      alsf_pkg::LD_CNT:  ld_val = W'(count);
      alsf_pkg::LD_CSUM: ld_val = W'(csum[ld.idx[1:0]]);
      alsf_pkg::LD_WSUM: ld_val = W'(wsum[ld.idx[1:0]]);
      alsf_pkg::LD_MOM:  ld_val = W'(mom[ld.idx]);
      default:           ld_val = alsf_pkg::FRAC_ONE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wa_ins;
    mem_wd = alu;
    case (state)
      S_LOAD: begin
        mem_we = 1'b1;
        mem_wa = ld.addr;
        mem_wd = ld_val;
      end
      S_EXEC: begin
        mem_we = (ins.op == alsf_pkg::OP_ADD) || (ins.op == alsf_pkg::OP_SUB);
      end
      S_MUL: begin
        mem_we = (my == '0);
        mem_wd = acc;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  assign rsh  = {rem[W-2:0], dn[W-1]};
  assign ge   = (rsh >= dv);
  assign rsub = rsh - dv;

  always_comb begin
    if (qov) begin
      sat = neg ? {1'b1, {(alsf_pkg::OUT_W-1){1'b0}}} : {1'b0, {(alsf_pkg::OUT_W-1){1'b1}}};
    end else if (neg) begin
      sat = q[alsf_pkg::OUT_W-1] ? {1'b1, {(alsf_pkg::OUT_W-1){1'b0}}} : -q;
    end else begin
      sat = q[alsf_pkg::OUT_W-1] ? {1'b0, {(alsf_pkg::OUT_W-1){1'b1}}} : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      for (int i = 0; i < 3; i++) begin
        csum[i] <= '0;
        wsum[i] <= '0;
      end
      for (int i = 0; i < alsf_pkg::MOM_N; i++) begin
        mom[i] <= '0;
      end
      result_valid <= 1'b0;
      kstep <= '0;
      ls <= '0;
      pc <= alsf_pkg::P_SETUP;
      k <= '0;
      in_row <= 1'b0;
      detz <= 1'b0;
    end else begin
      if (mem_we && mem_wa == alsf_pkg::R_DET) begin
        detz <= (mem_wd == '0);
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            pt <= item;
            kstep <= '0;
            ls <= '0;
            if (count < CNT_W'(MAX_POINTS)) begin
              count <= count + 1'b1;
              csum[0] <= csum[0] + SUM_W'(item.cam_x);
              csum[1] <= csum[1] + SUM_W'(item.cam_y);
              csum[2] <= csum[2] + SUM_W'(item.cam_z);
              wsum[0] <= wsum[0] + SUM_W'(item.world_x);
              wsum[1] <= wsum[1] + SUM_W'(item.world_y);
              wsum[2] <= wsum[2] + SUM_W'(item.world_z);
              state <= S_ACC;
            end else if (item.last_point) begin
              state <= S_LOAD;
            end
          end
        end
        S_ACC: begin
          mom[kstep] <= mom[kstep] + MOM_W'(prod);
          kstep <= kstep + 1'b1;
          if (kstep == 4'(alsf_pkg::MOM_N - 1)) begin
            state <= pt.last_point ? S_LOAD : S_IDLE;
          end
        end
        S_LOAD: begin
          ls <= ls + 1'b1;
          if (ls == alsf_pkg::LD_W'(alsf_pkg::LD_N - 1)) begin
            pc <= alsf_pkg::P_SETUP;
            in_row <= 1'b0;
            k <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (ins.op == alsf_pkg::OP_END) begin
            if (!in_row) begin
              in_row <= 1'b1;
              pc <= detz ? alsf_pkg::P_SING : alsf_pkg::P_ROW;
              for (int i = 0; i < 4; i++) fld[i] <= '0;
            end else begin
              result.row_index <= k;
              result.coef_x <= fld[alsf_pkg::F_CX];
              result.coef_y <= fld[alsf_pkg::F_CY];
              result.coef_z <= fld[alsf_pkg::F_CZ];
              result.offset <= fld[alsf_pkg::F_OFS];
              result.singular <= detz;
              result.last_row <= (k == 2'(alsf_pkg::ROWS - 1));
              result_valid <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (ins.op)
            alsf_pkg::OP_MUL: begin
              mx <= rd_a;
              my <= rd_b;
              acc <= '0;
              state <= S_MUL;
            end
            alsf_pkg::OP_DIV: begin
              neg <= rd_a[W-1] ^ rd_b[W-1];
              dn <= rd_a[W-1] ? -rd_a : rd_a;
              dv <= rd_b[W-1] ? -rd_b : rd_b;
              rem <= '0;
              q <= '0;
              qov <= 1'b0;
              dcnt <= '0;
              state <= S_DIV;
            end
            default: begin
              pc <= pc + 1'b1;
              state <= S_FETCH;
            end
          endcase
        end
        S_MUL: begin
          if (my == '0) begin
            pc <= pc + 1'b1;
            state <= S_FETCH;
          end else begin
            acc <= acc + (my[0] ? mx : '0);
            mx <= {mx[W-2:0], 1'b0};
            my <= {1'b0, my[W-1:1]};
          end
        end
        S_DIV: begin
          dn <= {dn[W-2:0], 1'b0};
          rem <= ge ? rsub : rsh;
          q <= {q[alsf_pkg::OUT_W-2:0], ge};
          qov <= qov | q[alsf_pkg::OUT_W-1];
          dcnt <= dcnt + 1'b1;
          if (dcnt == DC_W'(W - 1)) begin
            state <= S_DIVF;
          end
        end
        S_DIVF: begin
          fld[ins.dst[1:0]] <= sat;
          pc <= pc + 1'b1;
          state <= S_FETCH;
        end
        S_OUT: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            if (k == 2'(alsf_pkg::ROWS - 1)) begin
              count <= '0;
              for (int i = 0; i < 3; i++) begin
                csum[i] <= '0;
                wsum[i] <= '0;
              end
              for (int i = 0; i < alsf_pkg::MOM_N; i++) begin
                mom[i] <= '0;
              end
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
              pc <= detz ? alsf_pkg::P_SING : alsf_pkg::P_ROW;
              for (int i = 0; i < 4; i++) fld[i] <= '0;
              state <= S_FETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state == S_OUT)
    else $error("result valid outside output state");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_row |-> result.row_index == 2'(alsf_pkg::ROWS - 1))
    else $error("last row flag on wrong row");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && result.last_row |=> count == '0 && state == S_IDLE)
    else $error("accumulators not cleared after solve");

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond limit");

  a_div_nz: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dv != '0)
    else $error("division by zero");

endmodule

`default_nettype wire
